// ===== hw/rtl/sic_pkg.sv =====
`default_nettype none

package sic_pkg;

	// Field widths
	localparam int X_W   = 24;              // Q7.16 interval bounds
	localparam int OUT_W = 48;              // Q31.16 integral
	localparam int PC_W  = 10;              // point count register

	localparam int MAX_POINTS  = 1023;
	localparam int POINT_LIMIT = (MAX_POINTS - 1) | 1;
	localparam logic [PC_W-1:0] PC_RESET = PC_W'(101);

	// Cubic evaluation widths
	localparam int SQ_W  = 31;              // rounded x^2, Q16, never negative
	localparam int CUF_W = SQ_W + 1 + X_W;  // x^2 * x before rounding
	localparam int F_W   = 40;              // f(x) in Q16
	localparam int ACC_W = 51;              // weighted sum of samples
	localparam int AMAG_W = ACC_W - 1;
	localparam int HALF_W = AMAG_W / 2;

	// Final scaling and division widths
	localparam int PP_W   = HALF_W + X_W;
	localparam int PROD_W = AMAG_W + X_W;   // |sum| * |end - start|
	localparam int QUO_W  = 56;             // quotient width, all bits produced by the final division
	localparam int HEAD_W = PROD_W - QUO_W; // dividend bits preloaded into the remainder
	localparam int DIVR_W = 28;             // 3 * m * 2^16
	localparam int M3_W   = PC_W + 2;
	localparam int CNT_W  = $clog2(QUO_W + 1);

	typedef struct packed {
		logic signed [X_W-1:0] interval_start;
		logic signed [X_W-1:0] interval_end;
	} sic_req_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] integral_value;
		logic                    saturated;
	} sic_res_t;

	typedef struct packed {
		logic load;       // latch bounds and sample count
		logic step_go;    // start the step division
		logic take_step;  // capture step quotient, reset generator and sum
		logic issue;      // issue one sample into the cubic pipeline
		logic mul_lo;
		logic mul_hi;
		logic mul_sum;
		logic final_go;   // start the final division
		logic emit;       // register the result and strobe it
	} sic_cmd_t;

	typedef struct packed {
		logic div_done;
		logic last_issue;
		logic pipe_empty;
	} sic_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/simpson_integrate_cubic.sv =====
// A transaction runs the step division, issues samples x_0 .. x_m, drains the pipeline, forms
//   the scaling products and runs the final division; m is the effective point count minus one.
// Busy stays high for the whole run and no new transaction is taken until it drops;
//   samples are issued one per cycle.
// The result strobe lasts one cycle and cannot be stalled.
// Reset (arst_n low, asynchronous): idle, no strobe, point count back to 101.
`default_nettype none

module simpson_integrate_cubic (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  sic_pkg::sic_req_t        request,
	output logic                     done,
	output sic_pkg::sic_res_t        result,
	input  logic                     cfg_we,
	input  logic [sic_pkg::PC_W-1:0] cfg_wdata
);
	import sic_pkg::*;

	// Controller sequences the transaction:
	//   load bounds -> divide |end - start| by m for the step quotient and remainder
	//   -> issue samples x_0 .. x_m, one per cycle, into the cubic pipeline
	//   -> drain and hold the weighted sum -> scale by |width| in two partial products
	//   -> divide by 3 * m * 2^16 -> sign, clip and strobe the result.
	// The datapath owns every register of the arithmetic; the two parts talk only
	// through the command and status structs below.
	sic_cmd_t cmd;
	sic_sts_t sts;

	sic_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Datapath: point count register, sample generator, six-stage cubic
	// pipeline, weighted accumulator, partial-product multiplier and the
	// shared restoring divider. The result register holds until the next transaction.
	sic_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.request   (request),
		.cmd       (cmd),
		.sts       (sts),
		.done      (done),
		.result    (result)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/sic_div.sv =====
`default_nettype none

module sic_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [sic_pkg::HEAD_W-1:0]  head,
	input  logic [sic_pkg::QUO_W-1:0]   body,
	input  logic [sic_pkg::DIVR_W-1:0]  divisor,
	input  logic [sic_pkg::CNT_W-1:0]   iters,
	output logic                        done,
	output logic [sic_pkg::QUO_W-1:0]   quo,
	output logic [sic_pkg::DIVR_W-1:0]  rem
);
	import sic_pkg::*;

	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] divisor_q;
	logic [QUO_W-1:0]  dvd_q;
	logic [QUO_W-1:0]  quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVR_W:0]   trial;
	logic [DIVR_W:0]   diff;
	logic              fits;

	// Restoring division, one quotient bit per cycle
	always_comb begin
		trial = {rem_q, dvd_q[QUO_W-1]};
		diff  = trial - {1'b0, divisor_q};
		fits  = trial >= {1'b0, divisor_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q     <= DIVR_W'(head);
			dvd_q     <= body;
			quo_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
			dvd_q <= {dvd_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sic_datapath.sv =====
`default_nettype none

module sic_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [sic_pkg::PC_W-1:0] cfg_wdata,
	input  sic_pkg::sic_req_t       request,
	input  sic_pkg::sic_cmd_t       cmd,
	output sic_pkg::sic_sts_t       sts,
	output logic                    done,
	output sic_pkg::sic_res_t       result
);
	import sic_pkg::*;

	localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(1) << (OUT_W - 1);
	localparam logic [QUO_W-1:0] POS_LIM = NEG_LIM - QUO_W'(1);
	localparam logic signed [CUF_W-1:0] RND_POS = CUF_W'(32768);
	localparam logic signed [CUF_W-1:0] RND_NEG = CUF_W'(32767);

	// Configuration
	logic [PC_W-1:0] point_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= PC_RESET;
		end else if (cfg_we) begin
			point_count_q <= cfg_wdata;
		end
	end

	// Effective point count (m + 1): odd, at least three, at most the limit
	logic [PC_W-1:0] pts_odd;
	logic [PC_W-1:0] pts_eff;

	always_comb begin
		pts_odd = point_count_q | PC_W'(1);
		if (pts_odd < PC_W'(3)) begin
			pts_eff = PC_W'(3);
		end else if (int'(pts_odd) > POINT_LIMIT) begin
			pts_eff = PC_W'(POINT_LIMIT);
		end else begin
			pts_eff = pts_odd;
		end
	end

	// Transaction operands
	logic signed [X_W-1:0] lo_q;
	logic [X_W-1:0]        wmag_q;
	logic                  wneg_q;
	logic [PC_W-1:0]       m_q;
	logic signed [X_W:0]   width_d;
	logic [X_W:0]          wabs_d;

	always_comb begin
		width_d = (X_W+1)'(request.interval_end) - (X_W+1)'(request.interval_start);
		wabs_d  = width_d[X_W] ? -width_d : width_d;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_q   <= request.interval_start;
			wmag_q <= wabs_d[X_W-1:0];
			wneg_q <= width_d[X_W];
			m_q    <= pts_eff - PC_W'(1);
		end
	end

	// Shared divider: step quotient first, final scaling at the end
	logic                 div_go;
	logic [HEAD_W-1:0]    div_head;
	logic [QUO_W-1:0]     div_body;
	logic [DIVR_W-1:0]    div_divisor;
	logic [CNT_W-1:0]     div_iters;
	logic                 div_done;
	logic [QUO_W-1:0]     div_quo;
	logic [DIVR_W-1:0]    div_rem;
	logic [PROD_W-1:0]    prod_q;
	logic [M3_W-1:0]      m3;

	always_comb begin
		m3     = M3_W'(m_q) + M3_W'({m_q, 1'b0});
		div_go = cmd.step_go | cmd.final_go;
		if (cmd.final_go) begin
			div_head    = prod_q[PROD_W-1 -: HEAD_W];
			div_body    = prod_q[QUO_W-1:0];
			div_divisor = DIVR_W'({m3, 16'b0});
			div_iters   = CNT_W'(QUO_W);
		end else begin
			div_head    = '0;
			div_body    = {wmag_q, (QUO_W-X_W)'(0)};
			div_divisor = DIVR_W'(m_q);
			div_iters   = CNT_W'(X_W);
		end
	end

	sic_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (div_go),
		.head    (div_head),
		.body    (div_body),
		.divisor (div_divisor),
		.iters   (div_iters),
		.done    (div_done),
		.quo     (div_quo),
		.rem     (div_rem)
	);

	// Sample generator: x_i = lo + trunc(width * i / m), kept as quotient and remainder
	logic [X_W-1:0]  stepq_q;
	logic [PC_W-1:0] stepr_q;
	logic [X_W-1:0]  qacc_q;
	logic [PC_W-1:0] racc_q;
	logic [PC_W-1:0] idx_q;
	logic [PC_W:0]   racc_sum;
	logic            wrap;
	logic [PC_W:0]   racc_next;
	logic signed [X_W:0] offs;
	logic signed [X_W:0] xsum;
	logic [1:0]      sh_gen;

	always_comb begin
		racc_sum  = {1'b0, racc_q} + {1'b0, stepr_q};
		wrap      = racc_sum >= {1'b0, m_q};
		racc_next = wrap ? racc_sum - {1'b0, m_q} : racc_sum;
		offs      = wneg_q ? -$signed({1'b0, qacc_q}) : $signed({1'b0, qacc_q});
		xsum      = (X_W+1)'(lo_q) + offs;
		// weights 1 at the ends, 4 at odd, 2 at inner even samples
		if (idx_q == '0 || idx_q == m_q) begin
			sh_gen = 2'd0;
		end else if (idx_q[0]) begin
			sh_gen = 2'd2;
		end else begin
			sh_gen = 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_step) begin
			stepq_q <= div_quo[X_W-1:0];
			stepr_q <= div_rem[PC_W-1:0];
			qacc_q  <= '0;
			racc_q  <= '0;
			idx_q   <= '0;
		end else if (cmd.issue) begin
			qacc_q <= qacc_q + stepq_q + X_W'(wrap);
			racc_q <= racc_next[PC_W-1:0];
			idx_q  <= idx_q + PC_W'(1);
		end
	end

	// Cubic pipeline
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [X_W-1:0]   x_s1, x_s2, x_s3, x_s4, x_s5;
	logic [1:0]              sh_s1, sh_s2, sh_s3, sh_s4, sh_s5, sh_s6;
	logic signed [2*X_W-1:0] sqf_s2;
	logic [SQ_W-1:0]         sq_s3, sq_s4, sq_s5;
	logic signed [CUF_W-1:0] cuf_s4;
	logic signed [F_W-1:0]   cu_s5;
	logic signed [F_W-1:0]   f_s6;
	logic [2*X_W:0]          sq_sum;
	logic signed [CUF_W-1:0] cu_sum;

	always_comb begin
		sq_sum = {1'b0, sqf_s2} + (2*X_W+1)'(32768);
		cu_sum = cuf_s4 + (cuf_s4[CUF_W-1] ? RND_NEG : RND_POS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		x_s1   <= xsum[X_W-1:0];
		sh_s1  <= sh_gen;
		sqf_s2 <= x_s1 * x_s1;
		x_s2   <= x_s1;
		sh_s2  <= sh_s1;
		sq_s3  <= sq_sum[16 +: SQ_W];
		x_s3   <= x_s2;
		sh_s3  <= sh_s2;
		cuf_s4 <= $signed({1'b0, sq_s3}) * x_s3;
		sq_s4  <= sq_s3;
		x_s4   <= x_s3;
		sh_s4  <= sh_s3;
		cu_s5  <= cu_sum[16 +: F_W];
		sq_s5  <= sq_s4;
		x_s5   <= x_s4;
		sh_s5  <= sh_s4;
		f_s6   <= cu_s5 - F_W'($signed({1'b0, sq_s5})) + F_W'(x_s5);
		sh_s6  <= sh_s5;
	end

	// Weighted sum
	logic signed [ACC_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (cmd.take_step) begin
			acc_q <= '0;
		end else if (v_s6) begin
			acc_q <= acc_q + (ACC_W'(f_s6) <<< sh_s6);
		end
	end

	// |sum| * |width| in two partial products on one multiplier
	logic [ACC_W-1:0]  amag;
	logic [HALF_W-1:0] mul_a;
	logic [PP_W-1:0]   pp_q;
	logic              rneg_q;

	always_comb begin
		amag  = acc_q[ACC_W-1] ? -acc_q : acc_q;
		mul_a = cmd.mul_hi ? amag[HALF_W +: HALF_W] : amag[HALF_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_lo || cmd.mul_hi) begin
			pp_q <= mul_a * wmag_q;
		end
		if (cmd.mul_hi) begin
			prod_q <= PROD_W'(pp_q);
		end else if (cmd.mul_sum) begin
			prod_q <= prod_q + {pp_q, HALF_W'(0)};
		end
		if (cmd.mul_sum) begin
			rneg_q <= acc_q[ACC_W-1] ^ wneg_q;
		end
	end

	// Sign, clip and register the result
	logic [QUO_W-1:0] quo_neg;
	sic_res_t         res_d;
	sic_res_t         result_q;
	logic             done_q;

	always_comb begin
		quo_neg = -div_quo;
		if (rneg_q) begin
			res_d.saturated      = div_quo > NEG_LIM;
			res_d.integral_value = res_d.saturated ? $signed(NEG_LIM[OUT_W-1:0])
			                                       : $signed(quo_neg[OUT_W-1:0]);
		end else begin
			res_d.saturated      = div_quo > POS_LIM;
			res_d.integral_value = res_d.saturated ? $signed(POS_LIM[OUT_W-1:0])
			                                       : $signed(div_quo[OUT_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q <= res_d;
		end
	end

	always_comb begin
		sts.div_done   = div_done;
		sts.last_issue = idx_q == m_q;
		sts.pipe_empty = !(v_s1 || v_s2 || v_s3 || v_s4 || v_s5 || v_s6);
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sic_ctrl.sv =====
`default_nettype none

module sic_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  sic_pkg::sic_sts_t sts,
	output logic              busy,
	output sic_pkg::sic_cmd_t cmd
);
	import sic_pkg::*;

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_STEP_GO   = 4'd1;
	localparam logic [3:0] ST_STEP_WAIT = 4'd2;
	localparam logic [3:0] ST_ISSUE     = 4'd3;
	localparam logic [3:0] ST_DRAIN     = 4'd4;
	localparam logic [3:0] ST_MUL_LO    = 4'd5;
	localparam logic [3:0] ST_MUL_HI    = 4'd6;
	localparam logic [3:0] ST_MUL_SUM   = 4'd7;
	localparam logic [3:0] ST_FIN_GO    = 4'd8;
	localparam logic [3:0] ST_FIN_WAIT  = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_STEP_GO;
				end
			end
			ST_STEP_GO: begin
				cmd.step_go = 1'b1;
				state_d     = ST_STEP_WAIT;
			end
			ST_STEP_WAIT: begin
				if (sts.div_done) begin
					cmd.take_step = 1'b1;
					state_d       = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				cmd.issue = 1'b1;
				if (sts.last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (sts.pipe_empty) begin
					state_d = ST_MUL_LO;
				end
			end
			ST_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = ST_MUL_SUM;
			end
			ST_MUL_SUM: begin
				cmd.mul_sum = 1'b1;
				state_d     = ST_FIN_GO;
			end
			ST_FIN_GO: begin
				cmd.final_go = 1'b1;
				state_d      = ST_FIN_WAIT;
			end
			ST_FIN_WAIT: begin
				if (sts.div_done) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != ST_IDLE;

endmodule

`default_nettype wire

// ===== hw/rtl/sic_checker.sv =====
`default_nettype none

module sic_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// A result never shows while a transaction is still running
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// An accepted transaction makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	// Every finished transaction delivers its result as busy drops
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// One result per transaction: the strobe is a single cycle
	a_one_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule

bind simpson_integrate_cubic sic_checker u_sic_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

`default_nettype wire
